/* rtl/gsbs_pkg.sv */
package gsbs_pkg;

  localparam int BLOCKS_WIDTH_DEF  = 20;
  localparam int ENTROPY_WIDTH_DEF = 32;
  localparam int RATE_WIDTH        = 16;
  localparam int SLOT_COUNT        = 3;

  localparam logic [RATE_WIDTH-1:0] RATE_RESET = 16'd32768;
  // 0.618 in Q0.16
  localparam logic [RATE_WIDTH-1:0] GOLD_Q16   = 16'd40501;

  typedef enum logic [1:0] {
    SLOT_HIGH = 2'd0,
    SLOT_MID  = 2'd1,
    SLOT_LOW  = 2'd2
  } slot_t;

endpackage

/* rtl/gsbs_in_if.sv */
interface gsbs_in_if
  import gsbs_pkg::*;
#(
  parameter int ENTROPY_WIDTH = ENTROPY_WIDTH_DEF,
  parameter int BLOCKS_WIDTH  = BLOCKS_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [ENTROPY_WIDTH-1:0] new_entropy;
  logic [BLOCKS_WIDTH-1:0]  new_blocks;

  modport source (output valid, output new_entropy, output new_blocks, input ready);
  modport sink   (input valid, input new_entropy, input new_blocks, output ready);
endinterface

/* rtl/gsbs_out_if.sv */
interface gsbs_out_if
  import gsbs_pkg::*;
#(
  parameter int BLOCKS_WIDTH = BLOCKS_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  source_slot;
  logic [BLOCKS_WIDTH-1:0]     start_blocks;
  logic signed [BLOCKS_WIDTH:0] merge_count;
  logic                        done_res;

  modport source (output valid, output source_slot, output start_blocks,
                  output merge_count, output done_res, input ready);
  modport sink   (input valid, input source_slot, input start_blocks,
                  input merge_count, input done_res, output ready);
endinterface

/* rtl/gsbs_step.sv */
module gsbs_step
  import gsbs_pkg::*;
#(
  parameter int BLOCKS_WIDTH  = BLOCKS_WIDTH_DEF,
  parameter int ENTROPY_WIDTH = ENTROPY_WIDTH_DEF
) (
  input  logic [RATE_WIDTH-1:0]     rate,
  input  logic [ENTROPY_WIDTH-1:0]  new_entropy,
  input  logic [BLOCKS_WIDTH-1:0]   new_blocks,
  input  logic                      slot_v   [SLOT_COUNT],
  input  logic [ENTROPY_WIDTH-1:0]  slot_e   [SLOT_COUNT],
  input  logic [BLOCKS_WIDTH-1:0]   slot_b   [SLOT_COUNT],
  input  logic                      done,
  output logic                      slot_v_nxt [SLOT_COUNT],
  output logic [ENTROPY_WIDTH-1:0]  slot_e_nxt [SLOT_COUNT],
  output logic [BLOCKS_WIDTH-1:0]   slot_b_nxt [SLOT_COUNT],
  output logic                      done_nxt,
  output slot_t                     source_slot,
  output logic [BLOCKS_WIDTH-1:0]   start_blocks,
  output logic signed [BLOCKS_WIDTH:0] merge_count
);

  slot_t                        dst;
  slot_t                        old_mid;
  slot_t                        gold_src;
  logic [BLOCKS_WIDTH-1:0]      bk [SLOT_COUNT];
  logic signed [BLOCKS_WIDTH:0] d01;
  logic signed [BLOCKS_WIDTH:0] d12;
  logic signed [BLOCKS_WIDTH:0] d02;
  logic signed [BLOCKS_WIDTH:0] dg;
  logic signed [BLOCKS_WIDTH:0] dg_abs;
  logic signed [BLOCKS_WIDTH:0] part_s;
  logic signed [BLOCKS_WIDTH:0] gold_merge;
  logic [BLOCKS_WIDTH-1:0]      mag;
  logic [BLOCKS_WIDTH-1:0]      mul_a;
  logic [RATE_WIDTH-1:0]        mul_b;
  logic [BLOCKS_WIDTH+RATE_WIDTH-1:0] prod;
  logic [BLOCKS_WIDTH-1:0]      part;
  logic                         low_empty;
  logic                         term;

  // file the report into the bracket
  always_comb begin
    slot_v_nxt = slot_v;
    slot_e_nxt = slot_e;
    slot_b_nxt = slot_b;
    old_mid    = (slot_b[SLOT_MID] > new_blocks) ? SLOT_HIGH : SLOT_LOW;
    if (!slot_v[SLOT_MID]) begin
      dst = SLOT_MID;
    end else if (new_entropy <= slot_e[SLOT_MID]) begin
      slot_v_nxt[old_mid] = 1'b1;
      slot_e_nxt[old_mid] = slot_e[SLOT_MID];
      slot_b_nxt[old_mid] = slot_b[SLOT_MID];
      dst = SLOT_MID;
    end else begin
      dst = (slot_b[SLOT_MID] > new_blocks) ? SLOT_LOW : SLOT_HIGH;
    end
    slot_v_nxt[dst] = 1'b1;
    slot_e_nxt[dst] = new_entropy;
    slot_b_nxt[dst] = new_blocks;
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      bk[i] = slot_v_nxt[i] ? slot_b_nxt[i] : '0;
    end
  end

  assign d01 = $signed({1'b0, bk[SLOT_HIGH]}) - $signed({1'b0, bk[SLOT_MID]});
  assign d12 = $signed({1'b0, bk[SLOT_MID]})  - $signed({1'b0, bk[SLOT_LOW]});
  assign d02 = $signed({1'b0, bk[SLOT_HIGH]}) - $signed({1'b0, bk[SLOT_LOW]});

  assign low_empty = !slot_v_nxt[SLOT_LOW];
  assign term = (slot_v_nxt[SLOT_HIGH] && d02 == (BLOCKS_WIDTH+1)'(2)) ||
                (!slot_v_nxt[SLOT_HIGH] && d12 == (BLOCKS_WIDTH+1)'(1));

  assign gold_src = (!slot_v_nxt[SLOT_HIGH] && bk[SLOT_MID] > bk[SLOT_LOW]) ? SLOT_MID :
                    (d01 >= d12) ? SLOT_HIGH : SLOT_MID;
  assign dg     = (gold_src == SLOT_HIGH) ? d01 : d12;
  assign dg_abs = dg[BLOCKS_WIDTH] ? -dg : dg;
  assign mag    = dg_abs[BLOCKS_WIDTH-1:0];

  // one shared multiplier: reduction step or golden step
  assign mul_a = low_empty ? bk[SLOT_MID] : mag;
  assign mul_b = low_empty ? rate : GOLD_Q16;
  assign prod  = {{RATE_WIDTH{1'b0}}, mul_a} * {{BLOCKS_WIDTH{1'b0}}, mul_b};
  assign part  = prod[BLOCKS_WIDTH+RATE_WIDTH-1:RATE_WIDTH];

  assign part_s     = $signed({1'b0, part});
  assign gold_merge = dg[BLOCKS_WIDTH] ? dg + part_s : dg - part_s;

  assign done_nxt = done | (low_empty ? (part == '0) : term);

  always_comb begin
    if (low_empty) begin
      source_slot = SLOT_MID;
      merge_count = part_s;
    end else if (done_nxt) begin
      source_slot = SLOT_MID;
      merge_count = '0;
    end else begin
      source_slot = gold_src;
      merge_count = gold_merge;
    end
  end

  always_comb begin
    case (source_slot)
      SLOT_HIGH: start_blocks = bk[SLOT_HIGH];
      SLOT_MID:  start_blocks = bk[SLOT_MID];
      SLOT_LOW:  start_blocks = bk[SLOT_LOW];
      default:   start_blocks = '0;
    endcase
  end

endmodule

/* rtl/golden_section_block_search_unit.sv */
// Golden-section search over the block count of a partition.
// in_if carries one report per item (entropy and block count). out_if
// returns one result per report: the slot to restart from, its block count,
// the number of blocks to merge next and the sticky done flag.
// Both channels use valid/ready; an item moves when both are high.
// cfg_wr_en with cfg_wr_data loads the Q0.16 reduction rate; write it only
// while no report is in flight.
// An input register feeds one pass of filing, compares and a single 20x16
// multiply into the result register, which drives out_if.
// Throughput: one report per cycle while out_if is not stalled.
// Stall: while out_if.ready is low the result holds; one more report waits
// in the input register, then in_if.ready drops.
// Reset: all bracket slots empty, done flag clear, rate 0.5 (32768),
// both stages empty.
module golden_section_block_search_unit
  import gsbs_pkg::*;
#(
  parameter int BLOCKS_WIDTH  = BLOCKS_WIDTH_DEF,
  parameter int ENTROPY_WIDTH = ENTROPY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [RATE_WIDTH-1:0] cfg_wr_data,
  gsbs_in_if.sink               in_if,
  gsbs_out_if.source            out_if
);

  logic                          s1_v_r;
  logic [ENTROPY_WIDTH-1:0]      s1_ent_r;
  logic [BLOCKS_WIDTH-1:0]       s1_blk_r;
  logic                          out_v_r;
  slot_t                         src_r;
  logic [BLOCKS_WIDTH-1:0]       start_r;
  logic signed [BLOCKS_WIDTH:0]  merge_r;
  logic                          done_r;
  logic [RATE_WIDTH-1:0]         rate_r;
  logic                          slot_v_r [SLOT_COUNT];
  logic [ENTROPY_WIDTH-1:0]      slot_e_r [SLOT_COUNT];
  logic [BLOCKS_WIDTH-1:0]       slot_b_r [SLOT_COUNT];

  logic                          slot_v_nxt [SLOT_COUNT];
  logic [ENTROPY_WIDTH-1:0]      slot_e_nxt [SLOT_COUNT];
  logic [BLOCKS_WIDTH-1:0]       slot_b_nxt [SLOT_COUNT];
  logic                          done_nxt;
  slot_t                         src_nxt;
  logic [BLOCKS_WIDTH-1:0]       start_nxt;
  logic signed [BLOCKS_WIDTH:0]  merge_nxt;

  logic out_load;
  logic s1_adv;

  assign out_load    = !out_v_r || out_if.ready;
  assign s1_adv      = s1_v_r && out_load;
  assign in_if.ready = !s1_v_r || out_load;

  gsbs_step #(
    .BLOCKS_WIDTH  (BLOCKS_WIDTH),
    .ENTROPY_WIDTH (ENTROPY_WIDTH)
  ) u_step (
    .rate         (rate_r),
    .new_entropy  (s1_ent_r),
    .new_blocks   (s1_blk_r),
    .slot_v       (slot_v_r),
    .slot_e       (slot_e_r),
    .slot_b       (slot_b_r),
    .done         (done_r),
    .slot_v_nxt   (slot_v_nxt),
    .slot_e_nxt   (slot_e_nxt),
    .slot_b_nxt   (slot_b_nxt),
    .done_nxt     (done_nxt),
    .source_slot  (src_nxt),
    .start_blocks (start_nxt),
    .merge_count  (merge_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      done_r   <= 1'b0;
      rate_r   <= RATE_RESET;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_v_r[i] <= 1'b0;
      end
    end else begin
      if (in_if.ready) begin
        s1_v_r <= in_if.valid;
      end
      if (out_load) begin
        out_v_r <= s1_v_r;
      end
      if (s1_adv) begin
        slot_v_r <= slot_v_nxt;
        done_r   <= done_nxt;
      end
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_ent_r <= in_if.new_entropy;
      s1_blk_r <= in_if.new_blocks;
    end
    if (s1_adv) begin
      slot_e_r <= slot_e_nxt;
      slot_b_r <= slot_b_nxt;
      src_r    <= src_nxt;
      start_r  <= start_nxt;
      merge_r  <= merge_nxt;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.source_slot  = src_r;
  assign out_if.start_blocks = start_r;
  assign out_if.merge_count  = merge_r;
  assign out_if.done_res     = done_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done flag cleared");

  a_mid_filled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> slot_v_r[SLOT_MID])
    else $error("middle slot empty after a report");

  a_done_from_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.done_res) |-> (out_if.source_slot == SLOT_MID))
    else $error("done result not from middle slot");

  a_never_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.source_slot != SLOT_LOW))
    else $error("result restarts from low slot");

endmodule

/* sim/tb_golden_section_block_search_unit.sv */
`timescale 1ns / 100ps

module tb_golden_section_block_search_unit;
  import gsbs_pkg::*;

  localparam int EW = ENTROPY_WIDTH_DEF;
  localparam int BW = BLOCKS_WIDTH_DEF;

  typedef struct packed {
    logic [2:0]               filled;
    logic [2:0][EW-1:0]       ent;
    logic [2:0][BW-1:0]       blks;
    logic                     done;
    logic [RATE_WIDTH-1:0]    rate;
  } bracket_t;

  typedef struct packed {
    slot_t                    src;
    logic [BW-1:0]            start;
    logic signed [BW:0]       merge;
    logic                     done;
  } search_result_t;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_TOGGLE
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [RATE_WIDTH-1:0] cfg_wr_data;

  gsbs_in_if  in_ch ();
  gsbs_out_if out_ch ();

  bracket_t       bracket;
  search_result_t pending_results[$];
  int             mismatch_count = 0;
  int             burst_left = 0;

  golden_section_block_search_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #6 clk = ~clk;

  function automatic longint slot_blocks(bracket_t b, slot_t s);
    return b.filled[s] ? longint'(b.blks[s]) : 64'sd0;
  endfunction

  function automatic search_result_t file_and_step(inout bracket_t b,
                                                   input logic [EW-1:0] e,
                                                   input logic [BW-1:0] n);
    search_result_t r;
    slot_t          dst;
    slot_t          old;
    longint         hi, mi, lo, d, mag, part, merge, sel;
    merge = 0;
    r.src = SLOT_MID;
    if (!b.filled[SLOT_MID]) begin
      dst = SLOT_MID;
    end else if (e <= b.ent[SLOT_MID]) begin
      old = (b.blks[SLOT_MID] > n) ? SLOT_HIGH : SLOT_LOW;
      b.filled[old] = 1'b1;
      b.ent[old] = b.ent[SLOT_MID];
      b.blks[old] = b.blks[SLOT_MID];
      dst = SLOT_MID;
    end else begin
      dst = (b.blks[SLOT_MID] > n) ? SLOT_LOW : SLOT_HIGH;
    end
    b.filled[dst] = 1'b1;
    b.ent[dst] = e;
    b.blks[dst] = n;

    hi = slot_blocks(b, SLOT_HIGH);
    mi = slot_blocks(b, SLOT_MID);
    lo = slot_blocks(b, SLOT_LOW);
    if (!b.filled[SLOT_LOW]) begin
      merge = (mi * longint'(b.rate)) >>> 16;
      if (merge == 0) b.done = 1'b1;
    end else begin
      if ((b.filled[SLOT_HIGH] && hi - lo == 2) || (!b.filled[SLOT_HIGH] && mi - lo == 1))
        b.done = 1'b1;
      if (!b.done) begin
        if (!b.filled[SLOT_HIGH] && mi > lo) r.src = SLOT_MID;
        else if (hi - mi >= mi - lo) r.src = SLOT_HIGH;
        else r.src = SLOT_MID;
        d = (r.src == SLOT_HIGH) ? hi - mi : mi - lo;
        mag = (d < 0) ? -d : d;
        // golden fraction product truncates toward zero
        part = (mag * longint'(GOLD_Q16)) >>> 16;
        if (d < 0) part = -part;
        merge = d - part;
      end
    end
    sel = (r.src == SLOT_HIGH) ? hi : mi;
    r.start = sel[BW-1:0];
    r.merge = merge[BW:0];
    r.done = b.done;
    return r;
  endfunction

  function automatic bracket_t after_report(bracket_t b, logic [EW-1:0] e, logic [BW-1:0] n);
    void'(file_and_step(b, e, n));
    return b;
  endfunction

  task automatic send_report(input logic [EW-1:0] e, input logic [BW-1:0] n);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.new_entropy <= e;
    in_ch.new_blocks <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(file_and_step(bracket, e, n));
    burst_left--;
  endtask

  // sends only if the report leaves the search open
  task automatic send_open_report(input logic [EW-1:0] e, input logic [BW-1:0] n,
                                  output bit sent);
    bracket_t nxt;
    nxt = after_report(bracket, e, n);
    sent = !nxt.done;
    if (sent) send_report(e, n);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_rate(input logic [RATE_WIDTH-1:0] value);
    wait_drained();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bracket.rate = value;
  endtask

  task automatic test_opening_reports();
    send_report(32'h8000_0000, {BW{1'b1}});
    send_report({EW{1'b1}}, {BW{1'b1}});
    send_report(32'h4000_0000, 20'h80000);
    send_report(32'h4000_0000, 20'h7FFFF);
  endtask

  // low slot stays empty: reports either replace the middle or go high
  task automatic test_shrink_random(input int count);
    logic [EW-1:0] e, ment;
    logic [BW-1:0] n;
    int unsigned   mid;
    bracket_t      nxt;
    int            sent;
    sent = 0;
    while (sent < count) begin
      mid = 32'(bracket.blks[SLOT_MID]);
      ment = bracket.ent[SLOT_MID];
      if ($urandom_range(0, 1) == 1 && mid > 1) begin
        e = $urandom_range(ment - ment / 8, ment);
        n = BW'($urandom_range(mid - 1 - mid / 32, mid - 1));
      end else begin
        e = $urandom_range(ment + 1, {EW{1'b1}});
        n = BW'($urandom_range(mid, {BW{1'b1}}));
      end
      nxt = after_report(bracket, e, n);
      if (!nxt.filled[SLOT_LOW] && !nxt.done) begin
        send_report(e, n);
        sent++;
      end
    end
  endtask

  task automatic test_reduction_rates();
    test_shrink_random(15);
    write_rate(16'd1);
    test_shrink_random(15);
    write_rate({RATE_WIDTH{1'b1}});
    test_shrink_random(15);
    write_rate(RATE_WIDTH'($urandom_range(2, 16'hFFFE)));
    test_shrink_random(15);
  endtask

  task automatic test_fill_low();
    bit sent;
    send_open_report(bracket.ent[SLOT_MID] + 1, BW'(bracket.blks[SLOT_MID] / 2), sent);
  endtask

  task automatic test_golden_directed();
    bit sent;
    send_open_report({EW{1'b1}}, '0, sent);
    send_open_report({EW{1'b1}}, {BW{1'b1}}, sent);
    send_open_report('0, 20'h40000, sent);
    send_open_report(32'd1, 20'h3FFF0, sent);
    send_open_report(32'd1, 20'h40010, sent);
    send_open_report('0, 20'h00010, sent);
    send_open_report(32'd2, 20'h00008, sent);
    send_open_report('0, 20'h00004, sent);
    send_open_report('0, 20'h00020, sent);
  endtask

  task automatic test_golden_random(input int count);
    logic [EW-1:0] e;
    logic [BW-1:0] n;
    int unsigned   base;
    int            sent;
    bit            ok;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 3))
        0: e = $urandom;
        1: e = $urandom_range(0, 255);
        2: begin
          base = bracket.ent[SLOT_MID];
          e = base + $urandom_range(0, 16) - 8;
        end
        default: e = ($urandom_range(0, 1) == 1) ? {EW{1'b1}} : '0;
      endcase
      case ($urandom_range(0, 4))
        0: n = BW'($urandom);
        1: n = BW'($urandom_range(0, 255));
        2, 3: begin
          base = 32'(bracket.blks[$urandom_range(0, 2)]);
          n = BW'(base + $urandom_range(0, 16) - 8);
        end
        default: n = ($urandom_range(0, 1) == 1) ? {BW{1'b1}} : '0;
      endcase
      send_open_report(e, n, ok);
      if (ok) begin
        sent++;
        if (sent % 300 == 0) wait_drained();
      end
    end
  endtask

  task automatic test_termination();
    send_report('0, 20'd1000);
    send_report(32'd5, 20'd1001);
    send_report(32'd5, 20'd999);
    send_report({EW{1'b1}}, {BW{1'b1}});
    send_report('0, '0);
    repeat (4) send_report($urandom, BW'($urandom));
  endtask

  initial begin
    stall_mode_t mode;
    int          left;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        RX_OPEN: out_ch.ready <= 1'b1;
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: source_slot %0d merge_count %0d",
               out_ch.source_slot, out_ch.merge_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.source_slot !== want.src) begin
          $error("source_slot: expected %0d, got %0d", want.src, out_ch.source_slot);
          mismatch_count++;
        end
        if (out_ch.start_blocks !== want.start) begin
          $error("start_blocks: expected %0d, got %0d", want.start, out_ch.start_blocks);
          mismatch_count++;
        end
        if (out_ch.merge_count !== want.merge) begin
          $error("merge_count: expected %0d, got %0d", want.merge, out_ch.merge_count);
          mismatch_count++;
        end
        if (out_ch.done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_ch.done_res);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.new_entropy = '0;
    in_ch.new_blocks = '0;
    bracket = '0;
    bracket.rate = RATE_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_opening_reports();
    test_reduction_rates();
    test_fill_low();
    test_golden_directed();
    test_golden_random(1100);
    write_rate('0);
    test_termination();

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* golden_section_block_search_unit.f */
rtl/gsbs_pkg.sv
rtl/gsbs_in_if.sv
rtl/gsbs_out_if.sv
rtl/gsbs_step.sv
rtl/golden_section_block_search_unit.sv
sim/tb_golden_section_block_search_unit.sv
